[sv/acfp_pkg.sv]
// Shared types, constants and the coordinate decoder for the ASCII coordinate frame parser.
// No dependencies; imported by ascii_coordinate_frame_parser_top.
package acfp_pkg;

    // Frame layout: header, mode, x sign, 3 x digits, y sign, 3 y digits, trailer
    localparam int unsigned FRAME_LEN = 11;
    localparam int unsigned CNT_W     = $clog2(FRAME_LEN);

    localparam logic [CNT_W-1:0] IDX_MODE    = CNT_W'(1);
    localparam logic [CNT_W-1:0] IDX_X_SIGN  = CNT_W'(2);
    localparam logic [CNT_W-1:0] IDX_Y_SIGN  = CNT_W'(6);
    localparam logic [CNT_W-1:0] IDX_TRAILER = CNT_W'(FRAME_LEN - 1);

    localparam logic [7:0] HDR_BYTE  = 8'h61;
    localparam logic [7:0] TRL_BYTE  = 8'h62;
    localparam logic [7:0] SIGN_NEG  = 8'h30;
    localparam logic [7:0] MODE_BASE = 8'h30;
    localparam logic [7:0] MODE_TOP  = 8'h34;

    localparam logic signed [15:0] DIGIT_BIAS = 16'sd48;

    // Event codes
    localparam logic [1:0] EV_TAKEN       = 2'd0;
    localparam logic [1:0] EV_BAD_HEADER  = 2'd1;
    localparam logic [1:0] EV_BAD_TRAILER = 2'd2;
    localparam logic [1:0] EV_ACCEPTED    = 2'd3;

    localparam int unsigned NUM_SLOTS = 4;

    typedef logic signed [15:0] t_coord;

    typedef struct packed {
        logic [1:0] event_res;
        logic [2:0] mode;
        t_coord     decoded_x;
        t_coord     decoded_y;
        t_coord [2*NUM_SLOTS-1:0] points;
    } t_result;

    // Sign byte plus three digits, each digit taken as (byte - 48) unchecked.
    // Range before sign is -5328..22977, so 16 bits signed always suffice.
    function automatic t_coord decode_value(input logic [7:0] sign_b,
                                            input logic [7:0] d0,
                                            input logic [7:0] d1,
                                            input logic [7:0] d2);
        t_coord v0;
        t_coord v1;
        t_coord v2;
        t_coord v;
        v0 = $signed({8'h00, d0}) - DIGIT_BIAS;
        v1 = $signed({8'h00, d1}) - DIGIT_BIAS;
        v2 = $signed({8'h00, d2}) - DIGIT_BIAS;
        v  = v0 * 16'sd100 + v1 * 16'sd10 + v2;
        if (sign_b == SIGN_NEG) begin
            v = -v;
        end
        return v;
    endfunction

endpackage

[sv/ascii_coordinate_frame_parser_top.sv]
// ASCII coordinate frame parser: byte-wise frame assembly and point store.
// Depends on acfp_pkg (frame constants, event codes, result struct, decoder).
//
// Usage:
//   Input channel carries one received byte per item (i_in_valid, o_in_stall,
//   i_rx_byte). Output channel gives one result item per input item
//   (o_out_valid, i_out_stall, o_* fields): an event code plus a snapshot of
//   mode, last decoded coordinates and all four point slots after that byte.
//   Results are registered in the output stage. Throughput: one item per
//   cycle while o_in_stall is low; the frame state updates in the accept
//   cycle, all decoding is one level of constant multiplies and adds.
//   A two-entry output stage (result register plus skid register) lets a
//   byte be accepted while a result waits; o_in_stall rises only once both
//   entries hold unread results, and it comes straight from a register.
//   Reset (i_rst_n low, synchronous) empties the output stage, clears the
//   byte count, mode, last coordinates and point slots. Frame buffer bytes
//   are not reset; each is written before it is read within a frame.
//   While the receiver stalls, the presented result holds unchanged.
module ascii_coordinate_frame_parser_top (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_rx_byte,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [1:0]              o_event_res,
    output logic [2:0]              o_mode,
    output acfp_pkg::t_coord        o_decoded_x,
    output acfp_pkg::t_coord        o_decoded_y,
    output acfp_pkg::t_coord        o_point1_x,
    output acfp_pkg::t_coord        o_point1_y,
    output acfp_pkg::t_coord        o_point2_x,
    output acfp_pkg::t_coord        o_point2_y,
    output acfp_pkg::t_coord        o_point3_x,
    output acfp_pkg::t_coord        o_point3_y,
    output acfp_pkg::t_coord        o_point4_x,
    output acfp_pkg::t_coord        o_point4_y
);
    import acfp_pkg::*;

    // ---------------- frame state ----------------
    logic [7:0]       r_buf [FRAME_LEN];   // bytes of current frame
    logic [CNT_W-1:0] r_count, n_count;    // bytes held, 0..10
    logic [2:0]       r_mode, n_mode;
    t_coord           r_last_x, n_last_x;
    t_coord           r_last_y, n_last_y;
    t_coord [2*NUM_SLOTS-1:0] r_points, n_points;

    // ---------------- output stage ----------------
    t_result r_out, n_out;
    t_result r_skid, n_skid;
    logic    r_out_valid, n_out_valid;
    logic    r_skid_valid, n_skid_valid;

    logic       in_acc;
    logic       out_free;
    logic [1:0] ev;
    t_result    res;
    logic [7:0] mode_b;
    logic [1:0] slot;

    assign o_in_stall = r_skid_valid;
    assign in_acc     = i_in_valid & ~r_skid_valid;
    assign out_free   = ~r_out_valid | ~i_out_stall;

    // Byte handling: the current byte is used directly where the frame needs
    // it (header at count 0, trailer at count 10); earlier bytes come from r_buf.
    always_comb begin
        n_count  = r_count;
        n_mode   = r_mode;
        n_last_x = r_last_x;
        n_last_y = r_last_y;
        n_points = r_points;
        ev       = EV_TAKEN;
        mode_b   = r_buf[IDX_MODE];
        slot     = 2'd0;

        if (r_count == '0) begin
            if (i_rx_byte != HDR_BYTE) begin
                ev = EV_BAD_HEADER;
            end else begin
                n_count = CNT_W'(1);
            end
        end else if (r_count != IDX_TRAILER) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_rx_byte != TRL_BYTE) begin
            n_count = '0;
            ev      = EV_BAD_TRAILER;
        end else begin
            n_count = '0;
            ev      = EV_ACCEPTED;
            if (mode_b >= MODE_BASE && mode_b <= MODE_TOP) begin
                n_mode = 3'(mode_b - MODE_BASE);
            end
            n_last_x = decode_value(r_buf[IDX_X_SIGN], r_buf[3], r_buf[4], r_buf[5]);
            n_last_y = decode_value(r_buf[IDX_Y_SIGN], r_buf[7], r_buf[8], r_buf[9]);
            if (n_mode >= 3'd1 && n_mode <= 3'd4) begin
                slot = 2'(n_mode - 3'd1);
                n_points[{slot, 1'b0}] = n_last_x;
                n_points[{slot, 1'b1}] = n_last_y;
            end
        end

        res.event_res = ev;
        res.mode      = n_mode;
        res.decoded_x = n_last_x;
        res.decoded_y = n_last_y;
        res.points    = n_points;
    end

    // Two-entry output stage
    always_comb begin
        n_out        = r_out;
        n_skid       = r_skid;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (out_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (in_acc) begin
                n_out       = res;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (in_acc) begin
            n_skid       = res;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_mode       <= '0;
            r_last_x     <= '0;
            r_last_y     <= '0;
            r_points     <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_count  <= n_count;
                r_mode   <= n_mode;
                r_last_x <= n_last_x;
                r_last_y <= n_last_y;
                r_points <= n_points;
            end
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_buf[r_count] <= i_rx_byte;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid = r_out_valid;
    assign o_event_res = r_out.event_res;
    assign o_mode      = r_out.mode;
    assign o_decoded_x = r_out.decoded_x;
    assign o_decoded_y = r_out.decoded_y;
    assign o_point1_x  = r_out.points[0];
    assign o_point1_y  = r_out.points[1];
    assign o_point2_x  = r_out.points[2];
    assign o_point2_y  = r_out.points[3];
    assign o_point3_x  = r_out.points[4];
    assign o_point3_y  = r_out.points[5];
    assign o_point4_x  = r_out.points[6];
    assign o_point4_y  = r_out.points[7];

endmodule

[tb/sv/ascii_coordinate_frame_parser_top_test.sv]
// Self-checking testbench for the ASCII coordinate frame parser top level.
// Depends on acfp_pkg and ascii_coordinate_frame_parser_top; no files or arguments.
// Frames are predicted byte by byte and every result item is checked in order.
module ascii_coordinate_frame_parser_top_test;
    import acfp_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RST_CYCLES  = 12;
    localparam int RAND_ITEMS  = 1130;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 8;
    localparam int IDLE_PCT    = 12;

    localparam logic [7:0] SIGN_POS = 8'h2b;
    localparam logic [7:0] ASCII_0  = 8'h30;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_rx_byte   = 8'h00;
    logic       i_out_stall = 1'b0;

    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_event_res;
    logic [2:0] o_mode;
    t_coord     o_decoded_x;
    t_coord     o_decoded_y;
    t_coord     o_point1_x;
    t_coord     o_point1_y;
    t_coord     o_point2_x;
    t_coord     o_point2_y;
    t_coord     o_point3_x;
    t_coord     o_point3_y;
    t_coord     o_point4_x;
    t_coord     o_point4_y;

    ascii_coordinate_frame_parser_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_event_res (o_event_res),
        .o_mode      (o_mode),
        .o_decoded_x (o_decoded_x),
        .o_decoded_y (o_decoded_y),
        .o_point1_x  (o_point1_x),
        .o_point1_y  (o_point1_y),
        .o_point2_x  (o_point2_x),
        .o_point2_y  (o_point2_y),
        .o_point3_x  (o_point3_x),
        .o_point3_y  (o_point3_y),
        .o_point4_x  (o_point4_x),
        .o_point4_y  (o_point4_y)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Frame predictor: its own copy of the frame buffer, fill count,
    // mode, last coordinates and the four point slots.
    // ------------------------------------------------------------------
    logic [7:0] rx_frame [FRAME_LEN];
    int unsigned rx_fill;
    logic [2:0]  mode_now;
    t_coord      pos_x;
    t_coord      pos_y;
    t_coord      slot_coord [2*NUM_SLOTS];

    // Snapshots still owed by the block, oldest first
    t_result     pending_snapshots [$];

    int          fail_count  = 0;
    int          frame_bytes = 0;   // items that were not header rejects

    // Shared knobs between the test tasks and the two handshake sides
    bit          idle_on   = 1'b1;
    bit          hold_req  = 1'b0;
    int          hold_left = 0;

    initial begin
        foreach (rx_frame[k]) rx_frame[k] = 8'h00;
        foreach (slot_coord[k]) slot_coord[k] = '0;
        rx_fill  = 0;
        mode_now = '0;
        pos_x    = '0;
        pos_y    = '0;
    end

    // Sign byte plus three digits; digits are not range-checked
    function automatic t_coord digits_to_coord(input logic [7:0] sgn,
                                               input logic [7:0] d_hi,
                                               input logic [7:0] d_mid,
                                               input logic [7:0] d_lo);
        int v;
        v = (int'(d_hi) - 48) * 100 + (int'(d_mid) - 48) * 10 + (int'(d_lo) - 48);
        if (sgn == SIGN_NEG) begin
            v = -v;
        end
        return t_coord'(v);
    endfunction

    task automatic predict_rx_byte(input logic [7:0] b);
        int unsigned pos;
        int unsigned slot;
        t_result     snap;
        pos = (rx_fill >= FRAME_LEN) ? 0 : rx_fill;
        rx_frame[pos] = b;
        pos++;
        if (rx_frame[0] != HDR_BYTE) begin
            // only the first byte of a frame is tested against the header
            rx_fill = 0;
            snap.event_res = EV_BAD_HEADER;
        end else if (pos < FRAME_LEN) begin
            rx_fill = pos;
            snap.event_res = EV_TAKEN;
        end else if (rx_frame[IDX_TRAILER] != TRL_BYTE) begin
            // bad trailer: whole frame dropped, nothing else moves
            rx_fill = 0;
            snap.event_res = EV_BAD_TRAILER;
        end else begin
            if (rx_frame[IDX_MODE] >= MODE_BASE && rx_frame[IDX_MODE] <= MODE_TOP) begin
                mode_now = 3'(rx_frame[IDX_MODE] - MODE_BASE);
            end
            pos_x = digits_to_coord(rx_frame[2], rx_frame[3], rx_frame[4], rx_frame[5]);
            pos_y = digits_to_coord(rx_frame[6], rx_frame[7], rx_frame[8], rx_frame[9]);
            // mode zero decodes but stores nowhere
            if (mode_now >= 1 && mode_now <= NUM_SLOTS) begin
                slot = mode_now - 1;
                slot_coord[2*slot]   = pos_x;
                slot_coord[2*slot+1] = pos_y;
            end
            rx_fill = 0;
            snap.event_res = EV_ACCEPTED;
        end
        if (snap.event_res != EV_BAD_HEADER) begin
            frame_bytes++;
        end
        snap.mode      = mode_now;
        snap.decoded_x = pos_x;
        snap.decoded_y = pos_y;
        for (int k = 0; k < 2*NUM_SLOTS; k++) begin
            snap.points[k] = slot_coord[k];
        end
        pending_snapshots.push_back(snap);
    endtask

    // ------------------------------------------------------------------
    // Input side: one item per call, held until the block takes it.
    // ------------------------------------------------------------------
    task automatic send_rx_byte(input logic [7:0] b);
        if (idle_on && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        predict_rx_byte(b);
    endtask

    task automatic send_frame(input logic [7:0] mode_b,
                              input logic [7:0] x_sgn, input logic [23:0] x_dig,
                              input logic [7:0] y_sgn, input logic [23:0] y_dig,
                              input logic [7:0] trailer);
        send_rx_byte(HDR_BYTE);
        send_rx_byte(mode_b);
        send_rx_byte(x_sgn);
        send_rx_byte(x_dig[23:16]);
        send_rx_byte(x_dig[15:8]);
        send_rx_byte(x_dig[7:0]);
        send_rx_byte(y_sgn);
        send_rx_byte(y_dig[23:16]);
        send_rx_byte(y_dig[15:8]);
        send_rx_byte(y_dig[7:0]);
        send_rx_byte(trailer);
    endtask

    task automatic wait_drained();
        while (pending_snapshots.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall, optional long hold-off, in-order check.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result snap;
        // sample with the stall value that held across this edge
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_snapshots.size() == 0) begin
                $display("%0t: result item with nothing expected, event %0d",
                         $time, o_event_res);
                fail_count++;
            end else begin
                snap = pending_snapshots.pop_front();
                check_field("event_res", snap.event_res, o_event_res);
                check_field("mode",      snap.mode,      o_mode);
                check_field("decoded_x", snap.decoded_x, o_decoded_x);
                check_field("decoded_y", snap.decoded_y, o_decoded_y);
                check_field("point1_x",  snap.points[0], o_point1_x);
                check_field("point1_y",  snap.points[1], o_point1_y);
                check_field("point2_x",  snap.points[2], o_point2_x);
                check_field("point2_y",  snap.points[3], o_point2_y);
                check_field("point3_x",  snap.points[4], o_point3_x);
                check_field("point3_y",  snap.points[5], o_point3_y);
                check_field("point4_x",  snap.points[6], o_point4_x);
                check_field("point4_y",  snap.points[7], o_point4_y);
            end
        end
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("ascii_coordinate_frame_parser_top_test NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // Random content helpers
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_digit();
        if ($urandom_range(99) < 85) begin
            return ASCII_0 + 8'($urandom_range(9));
        end
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] rand_sign();
        case ($urandom_range(3))
            0, 1: begin
                return SIGN_NEG;
            end
            2: begin
                return SIGN_POS;
            end
            default: begin
                return 8'($urandom_range(255));
            end
        endcase
    endfunction

    function automatic logic [7:0] rand_mode_byte();
        if ($urandom_range(99) < 85) begin
            return MODE_BASE + 8'($urandom_range(4));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_frame();
        logic [7:0] trl;
        trl = ($urandom_range(99) < 90) ? TRL_BYTE : 8'($urandom_range(255));
        send_frame(rand_mode_byte(),
                   rand_sign(), {rand_digit(), rand_digit(), rand_digit()},
                   rand_sign(), {rand_digit(), rand_digit(), rand_digit()},
                   trl);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_header_reject();
        send_rx_byte(8'h00);
        send_rx_byte(8'hff);
    endtask

    // Largest magnitude (non-digit 0xff) negated, smallest raw value
    // (0x00 digits), then an out-of-range mode byte with a bad trailer.
    task automatic test_extreme_frames();
        send_frame(MODE_BASE + 8'd1, SIGN_NEG, 24'hffffff, SIGN_POS, 24'h000000, TRL_BYTE);
        send_frame(8'h2f, SIGN_POS, 24'h393939, SIGN_NEG, 24'h393939, 8'h63);
    endtask

    // Receiver holds off while the sender keeps pushing frames
    task automatic test_backpressure();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        repeat (4) send_random_frame();
        idle_on  = 1'b1;
    endtask

    // Sender waits for every owed result before carrying on
    task automatic test_drain_pause();
        send_random_frame();
        i_in_valid <= 1'b0;
        wait_drained();
        send_random_frame();
    endtask

    task automatic test_random_stream();
        int start_count;
        int pick;
        start_count = frame_bytes;
        while (frame_bytes - start_count < RAND_ITEMS) begin
            // a long stretch in the middle with no idling on either side
            idle_on = !((frame_bytes - start_count) inside {[400:650]});
            pick = $urandom_range(99);
            if (pick < 85) begin
                send_random_frame();
            end else if (pick < 95) begin
                repeat ($urandom_range(4, 1)) send_rx_byte(8'($urandom_range(255)));
            end else begin
                // truncated frame: following bytes fill out its remainder
                send_rx_byte(HDR_BYTE);
                repeat ($urandom_range(8, 1)) send_rx_byte(8'($urandom_range(255)));
            end
        end
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_header_reject();
        test_extreme_frames();
        test_backpressure();
        test_drain_pause();
        test_random_stream();

        i_in_valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_snapshots.size() != 0) begin
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("ascii_coordinate_frame_parser_top_test OK");
        end else begin
            $display("ascii_coordinate_frame_parser_top_test NOT OK");
        end
        $finish;
    end

endmodule
